FILE: hw/rtl/mfr_pkg.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver package
// Shared constants, result codes and the queue entry type of the receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mfr_pkg;

  // First byte of every valid packet.
  localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
  // Payload bytes are delivered with this value subtracted.
  localparam logic [7:0] PAYLOAD_OFFSET = 8'd1;

  // Division of the size word by three entry words: multiply by the
  // rounded-up reciprocal 2^17/3 and keep the upper bits.
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int          DIV3_SHIFT = 17;

  // Configuration port widths and register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_NODE_ID  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUTING_TYPE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_TYPE    = 2'd2;

  // Reset value of the data type code register.
  localparam logic [7:0] DATA_TYPE_RESET = 8'd1;

  // Default depth of the queue between parser and output stage.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ROUTE   = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // One result as it travels from parser to output stage. The three words
  // carry the route entry (hop, node, level) or the message id in word0.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] word0;
    logic [15:0] word1;
    logic [15:0] word2;
    logic [15:0] dest;
    logic [15:0] src;
    logic [15:0] hop;
    logic [7:0]  ftype;
    logic        fwd;
    logic        last;
  } q_entry_t;

  // Queue status seen by the parser and the output stage.
  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mfr_if.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver channel interfaces
// Byte input channel, result channel and configuration write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       packet_start;

  modport source (output valid, output rx_byte, output packet_start, input ready);
  modport sink   (input valid, input rx_byte, input packet_start, output ready);
endinterface

// Decoded result channel.
interface mfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [7:0]  payload_byte;
  logic [15:0] route_next_hop;
  logic [15:0] route_node;
  logic [15:0] route_level;
  logic [15:0] dest_addr;
  logic [15:0] src_addr;
  logic [15:0] hop_addr;
  logic [7:0]  frame_type;
  logic [15:0] message_id;
  logic        forward_flag;
  logic        last_of_frame;

  modport source (
    output valid, output item_kind, output payload_byte, output route_next_hop,
    output route_node, output route_level, output dest_addr, output src_addr,
    output hop_addr, output frame_type, output message_id, output forward_flag,
    output last_of_frame, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input route_next_hop,
    input route_node, input route_level, input dest_addr, input src_addr,
    input hop_addr, input frame_type, input message_id, input forward_flag,
    input last_of_frame, output ready
  );
endinterface

// Configuration register write channel.
interface mfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mfr_front.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver parser
// Holds the configuration registers, walks the frame byte by byte and
// pushes one queue entry for every byte that completes a result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfr_front
  import mfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  mfr_in_if.sink        in_ch,
  mfr_cfg_if.sink       cfg_ch,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output q_entry_t      push_entry
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_DST_L, PH_DST_H, PH_SRC_L, PH_SRC_H, PH_HOP_L, PH_HOP_H,
    PH_TYPE, PH_SIZ_L, PH_SIZ_H, PH_PAY, PH_MID_L, PH_MID_H,
    PH_EHOP, PH_ENODE, PH_ELEVEL
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic [15:0] dest_r, dest_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] hop_r, hop_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] entry_hop_r, entry_hop_nxt;
  logic [15:0] entry_node_r, entry_node_nxt;
  logic        word_hi_r, word_hi_nxt;

  logic [15:0] own_id_r;
  logic [7:0]  routing_code_r;
  logic [7:0]  data_code_r;

  logic        in_acc;
  logic [7:0]  b;
  logic [15:0] word;
  logic [31:0] div_prod;
  logic [15:0] size_div3;
  logic [15:0] rem_dec;

  // Bytes are taken whenever the queue has room for a possible result.
  assign in_ch.ready  = ~q_stat.full;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign b            = in_ch.rx_byte;

  // Little-endian word from the held low byte and the current byte.
  assign word      = {b, low_hold_r};
  assign div_prod  = 32'(word) * 32'(DIV3_RECIP);
  assign size_div3 = {1'b0, div_prod[31:DIV3_SHIFT]};
  assign rem_dec   = remaining_r - 16'd1;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r       <= '0;
      routing_code_r <= '0;
      data_code_r    <= DATA_TYPE_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_OWN_NODE_ID:  own_id_r       <= cfg_ch.data;
        REG_ROUTING_TYPE: routing_code_r <= cfg_ch.data[7:0];
        REG_DATA_TYPE:    data_code_r    <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  // Frame walk and result generation.
  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    low_hold_nxt   = low_hold_r;
    dest_nxt       = dest_r;
    src_nxt        = src_r;
    hop_nxt        = hop_r;
    type_nxt       = type_r;
    entry_hop_nxt  = entry_hop_r;
    entry_node_nxt = entry_node_r;
    word_hi_nxt    = word_hi_r;
    push           = 1'b0;

    push_entry           = '0;
    push_entry.dest      = dest_r;
    push_entry.src       = src_r;
    push_entry.hop       = hop_r;
    push_entry.ftype     = type_r;

    if (in_acc) begin
      if (in_ch.packet_start) begin
        // A start byte always opens a new packet.
        word_hi_nxt = 1'b0;
        phase_nxt   = (b == PREAMBLE_BYTE) ? PH_DST_L : PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_DST_L, PH_SRC_L, PH_HOP_L, PH_SIZ_L, PH_MID_L: begin
            low_hold_nxt = b;
            phase_nxt    = phase_t'(phase_r + 4'd1);
          end
          PH_DST_H: begin
            dest_nxt  = word;
            phase_nxt = PH_SRC_L;
          end
          PH_SRC_H: begin
            src_nxt   = word;
            phase_nxt = PH_HOP_L;
          end
          PH_HOP_H: begin
            hop_nxt   = word;
            phase_nxt = PH_TYPE;
          end
          PH_TYPE: begin
            type_nxt  = b;
            phase_nxt = PH_SIZ_L;
          end
          PH_SIZ_H: begin
            if (type_r == routing_code_r) begin
              remaining_nxt = size_div3;
              word_hi_nxt   = 1'b0;
              phase_nxt     = (size_div3 != '0) ? PH_EHOP : PH_IDLE;
            end else begin
              remaining_nxt = word;
              phase_nxt     = (word != '0) ? PH_PAY : PH_MID_L;
            end
          end
          PH_PAY: begin
            push                 = 1'b1;
            push_entry.kind      = KIND_PAYLOAD;
            push_entry.data_byte = b - PAYLOAD_OFFSET;
            remaining_nxt        = rem_dec;
            if (rem_dec == '0) begin
              phase_nxt = PH_MID_L;
            end
          end
          PH_MID_H: begin
            push             = 1'b1;
            push_entry.kind  = KIND_END;
            push_entry.word0 = word;
            push_entry.fwd   = (type_r == data_code_r) && (hop_r == own_id_r);
            push_entry.last  = 1'b1;
            phase_nxt        = PH_IDLE;
          end
          PH_EHOP, PH_ENODE, PH_ELEVEL: begin
            if (!word_hi_r) begin
              low_hold_nxt = b;
              word_hi_nxt  = 1'b1;
            end else begin
              word_hi_nxt = 1'b0;
              priority case (phase_r)
                PH_EHOP: begin
                  entry_hop_nxt = word;
                  phase_nxt     = PH_ENODE;
                end
                PH_ENODE: begin
                  entry_node_nxt = word;
                  phase_nxt      = PH_ELEVEL;
                end
                default: begin
                  push             = 1'b1;
                  push_entry.kind  = KIND_ROUTE;
                  push_entry.word0 = entry_hop_r;
                  push_entry.word1 = entry_node_r;
                  push_entry.word2 = word;
                  push_entry.last  = (rem_dec == '0);
                  remaining_nxt    = rem_dec;
                  phase_nxt        = (rem_dec == '0) ? PH_IDLE : PH_EHOP;
                end
              endcase
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      remaining_r  <= '0;
      low_hold_r   <= '0;
      dest_r       <= '0;
      src_r        <= '0;
      hop_r        <= '0;
      type_r       <= '0;
      entry_hop_r  <= '0;
      entry_node_r <= '0;
      word_hi_r    <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      low_hold_r   <= low_hold_nxt;
      dest_r       <= dest_nxt;
      src_r        <= src_nxt;
      hop_r        <= hop_nxt;
      type_r       <= type_nxt;
      entry_hop_r  <= entry_hop_nxt;
      entry_node_r <= entry_node_nxt;
      word_hi_r    <= word_hi_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mfr_queue.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver result queue
// Small first-in first-out buffer between the parser and the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfr_queue
  import mfr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_stat_t       q_stat,
  output q_entry_t      head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.avail = (count_r != '0);
  assign head_entry   = mem[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mfr_back.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver output stage
// Takes entries from the queue and presents them as result items, with the
// fields that do not belong to the item's kind forced to zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mfr_back
  import mfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire q_stat_t  q_stat,
  input  wire q_entry_t head_entry,
  output logic          pop,
  mfr_out_if.source     out_ch
);

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  pay_r;
  logic [15:0] rhop_r, rnode_r, rlevel_r;
  logic [15:0] dest_r, src_r, hop_r;
  logic [7:0]  ftype_r;
  logic [15:0] mid_r;
  logic        fwd_r, last_r;

  logic        is_pay, is_route, is_end;

  // Load a new item when the output register is empty or being taken.
  assign pop = q_stat.avail & (~valid_r | out_ch.ready);

  assign is_pay   = (head_entry.kind == KIND_PAYLOAD);
  assign is_route = (head_entry.kind == KIND_ROUTE);
  assign is_end   = (head_entry.kind == KIND_END);

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Output payload register, expanded by kind.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= head_entry.kind;
      pay_r    <= is_pay   ? head_entry.data_byte : '0;
      rhop_r   <= is_route ? head_entry.word0 : '0;
      rnode_r  <= is_route ? head_entry.word1 : '0;
      rlevel_r <= is_route ? head_entry.word2 : '0;
      mid_r    <= is_end   ? head_entry.word0 : '0;
      fwd_r    <= is_end & head_entry.fwd;
      last_r   <= head_entry.last;
      dest_r   <= head_entry.dest;
      src_r    <= head_entry.src;
      hop_r    <= head_entry.hop;
      ftype_r  <= head_entry.ftype;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.item_kind      = kind_r;
  assign out_ch.payload_byte   = pay_r;
  assign out_ch.route_next_hop = rhop_r;
  assign out_ch.route_node     = rnode_r;
  assign out_ch.route_level    = rlevel_r;
  assign out_ch.dest_addr      = dest_r;
  assign out_ch.src_addr       = src_r;
  assign out_ch.hop_addr       = hop_r;
  assign out_ch.frame_type     = ftype_r;
  assign out_ch.message_id     = mid_r;
  assign out_ch.forward_flag   = fwd_r;
  assign out_ch.last_of_frame  = last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/mesh_frame_receiver_core.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver core
// Byte-serial receiver for small mesh radio frames: header decode, route
// entry and payload extraction, and frame-end reporting.
// ---------------------------------------------------------------------------
//  Channel   Direction  Item
//  in_ch     sink       one received byte plus packet start marker
//  out_ch    source     one decoded result (payload byte, route entry, end)
//  cfg_ch    sink       register write: index and data, always ready
//
//  One byte is accepted per clock while the result queue is not full; the parser
//  decides each byte combinationally, by the frame walk and the size/3 multiplier.
//  Each result is written to the queue, then loaded into the output register.
//  Reset (synchronous, active low) empties the queue and returns to idle.
//  Bytes stall only while the result queue is full; a stalled output
//  leaves the parser running until the queue fills.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mesh_frame_receiver_core
  import mfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mfr_in_if.sink    in_ch,
  mfr_out_if.source out_ch,
  mfr_cfg_if.sink   cfg_ch
);

  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t head_entry;
  logic     push;
  logic     pop;

  // Parser and configuration registers.
  mfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Result queue.
  mfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_stat     (q_stat),
    .head_entry (head_entry)
  );

  // Output stage.
  mfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

FILE: sim/mesh_frame_receiver_core_test.sv
// ---------------------------------------------------------------------------
// Mesh frame receiver core testbench
// Sends packets byte by byte into the receiver and follows every accepted
// byte with a software copy of the frame walk. Each result that leaves the
// core is compared field by field with the oldest predicted result. A short
// directed part covers header extremes, empty frames, broken packets and
// register settings. Random traffic with random gaps and output stalls
// follows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_frame_receiver_core_test;
  import mfr_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  // Cycles to wait after the last result before the registers are touched.
  localparam int DRAIN_CYCLES = 8;
  // Parsed bytes in the random part and the number of register settings.
  localparam int RANDOM_BYTES = 2000;
  localparam int RANDOM_PHASES = 8;

  // Walk through the fields of one packet.
  typedef enum logic [3:0] {
    ST_IDLE, ST_DST_L, ST_DST_H, ST_SRC_L, ST_SRC_H, ST_HOP_L, ST_HOP_H,
    ST_TYPE, ST_SIZE_L, ST_SIZE_H, ST_PAY, ST_MID_L, ST_MID_H,
    ST_EHOP, ST_ENODE, ST_ELEVEL
  } rx_state_t;

  // One decoded result as it should appear on the output channel.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  pay;
    logic [15:0] r_hop;
    logic [15:0] r_node;
    logic [15:0] r_level;
    logic [15:0] dest;
    logic [15:0] src;
    logic [15:0] hop;
    logic [7:0]  ftype;
    logic [15:0] mid;
    logic        fwd;
    logic        last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mfr_in_if  in_bus ();
  mfr_out_if out_bus ();
  mfr_cfg_if cfg_bus ();

  mesh_frame_receiver_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Register copies, reset values.
  logic [15:0] own_id     = 16'd0;
  logic [7:0]  route_code = 8'd0;
  logic [7:0]  data_code  = DATA_TYPE_RESET;

  // Frame walk state, reset values.
  rx_state_t   rx_state   = ST_IDLE;
  logic [15:0] bytes_left = 16'd0;
  logic [7:0]  low_byte   = 8'd0;
  logic [15:0] cur_dest   = 16'd0;
  logic [15:0] cur_src    = 16'd0;
  logic [15:0] cur_hop    = 16'd0;
  logic [7:0]  cur_type   = 8'd0;
  logic [15:0] ent_hop    = 16'd0;
  logic [15:0] ent_node   = 16'd0;
  logic        hi_half    = 1'b0;

  frame_result_t expected_results[$];
  int            bytes_parsed = 0;
  int            error_count = 0;
  bit            no_gaps = 1'b0;

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Follow one accepted byte through the frame walk and queue any result.
  task automatic predict_byte(input logic [7:0] b, input logic start);
    frame_result_t r;
    logic [15:0]   w;
    logic          emit_now;
    r = '0;
    w = {b, low_byte};
    emit_now = 1'b0;
    if (start || rx_state != ST_IDLE) bytes_parsed++;
    if (start) begin
      // A start byte always opens a new packet, whatever was in progress.
      hi_half = 1'b0;
      rx_state = (b == PREAMBLE_BYTE) ? ST_DST_L : ST_IDLE;
    end else begin
      case (rx_state)
        ST_DST_L: begin
          low_byte = b;
          rx_state = ST_DST_H;
        end
        ST_DST_H: begin
          cur_dest = w;
          rx_state = ST_SRC_L;
        end
        ST_SRC_L: begin
          low_byte = b;
          rx_state = ST_SRC_H;
        end
        ST_SRC_H: begin
          cur_src = w;
          rx_state = ST_HOP_L;
        end
        ST_HOP_L: begin
          low_byte = b;
          rx_state = ST_HOP_H;
        end
        ST_HOP_H: begin
          cur_hop = w;
          rx_state = ST_TYPE;
        end
        ST_TYPE: begin
          cur_type = b;
          rx_state = ST_SIZE_L;
        end
        ST_SIZE_L: begin
          low_byte = b;
          rx_state = ST_SIZE_H;
        end
        ST_SIZE_H: begin
          // The routing meaning wins when both codes match.
          if (cur_type == route_code) begin
            bytes_left = w / 16'd3;
            hi_half = 1'b0;
            rx_state = (bytes_left != 16'd0) ? ST_EHOP : ST_IDLE;
          end else begin
            bytes_left = w;
            rx_state = (w != 16'd0) ? ST_PAY : ST_MID_L;
          end
        end
        ST_PAY: begin
          r.kind = KIND_PAYLOAD;
          r.pay = b - PAYLOAD_OFFSET;
          emit_now = 1'b1;
          bytes_left--;
          if (bytes_left == 16'd0) rx_state = ST_MID_L;
        end
        ST_MID_L: begin
          low_byte = b;
          rx_state = ST_MID_H;
        end
        ST_MID_H: begin
          r.kind = KIND_END;
          r.mid = w;
          r.fwd = (cur_type == data_code) && (cur_hop == own_id);
          r.last = 1'b1;
          emit_now = 1'b1;
          rx_state = ST_IDLE;
        end
        ST_EHOP, ST_ENODE, ST_ELEVEL: begin
          // Entry words arrive as low byte, then high byte.
          if (!hi_half) begin
            low_byte = b;
            hi_half = 1'b1;
          end else begin
            hi_half = 1'b0;
            case (rx_state)
              ST_EHOP: begin
                ent_hop = w;
                rx_state = ST_ENODE;
              end
              ST_ENODE: begin
                ent_node = w;
                rx_state = ST_ELEVEL;
              end
              default: begin
                bytes_left--;
                r.kind = KIND_ROUTE;
                r.r_hop = ent_hop;
                r.r_node = ent_node;
                r.r_level = w;
                r.last = (bytes_left == 16'd0);
                emit_now = 1'b1;
                rx_state = (bytes_left == 16'd0) ? ST_IDLE : ST_EHOP;
              end
            endcase
          end
        end
        default: rx_state = ST_IDLE;
      endcase
    end
    if (emit_now) begin
      r.dest = cur_dest;
      r.src = cur_src;
      r.hop = cur_hop;
      r.ftype = cur_type;
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  // Input gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Send one byte after a random gap and wait until the core takes it.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.rx_byte <= b;
    in_bus.packet_start <= start;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_byte(b, start);
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0], 1'b0);
    send_byte(w[15:8], 1'b0);
  endtask

  // Preamble and the fixed header fields up to and including the size word.
  task automatic send_header(input logic [15:0] dest, input logic [15:0] src,
                             input logic [15:0] hop, input logic [7:0] ftype,
                             input logic [15:0] size);
    send_byte(PREAMBLE_BYTE, 1'b1);
    send_word(dest);
    send_word(src);
    send_word(hop);
    send_byte(ftype, 1'b0);
    send_word(size);
  endtask

  task automatic send_data_frame(input logic [15:0] dest, input logic [15:0] src,
                                 input logic [15:0] hop, input logic [7:0] ftype,
                                 input logic [15:0] size, input logic [15:0] mid);
    send_header(dest, src, hop, ftype, size);
    repeat (size) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_word(mid);
  endtask

  task automatic send_route_frame(input logic [15:0] dest, input logic [15:0] src,
                                  input logic [15:0] hop, input logic [15:0] size);
    send_header(dest, src, hop, route_code, size);
    repeat ((size / 3) * 3) send_word(16'($urandom_range(0, 65535)));
  endtask

  // Register write; the copy follows the core's masking of narrow registers.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_OWN_NODE_ID:  own_id = value;
      REG_ROUTING_TYPE: route_code = value[7:0];
      REG_DATA_TYPE:    data_code = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Stop sending, let every expected result arrive, then let the core settle.
  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string field_name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h",
               $time, field_name, want_v, got_v);
    end
  endtask

  // Compare each result taken from the core with the oldest prediction.
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, got kind %h last %b",
                 $time, out_bus.item_kind, out_bus.last_of_frame);
      end else begin
        want = expected_results.pop_front();
        check_field("item_kind", 16'(want.kind), 16'(out_bus.item_kind));
        check_field("payload_byte", 16'(want.pay), 16'(out_bus.payload_byte));
        check_field("route_next_hop", want.r_hop, out_bus.route_next_hop);
        check_field("route_node", want.r_node, out_bus.route_node);
        check_field("route_level", want.r_level, out_bus.route_level);
        check_field("dest_addr", want.dest, out_bus.dest_addr);
        check_field("src_addr", want.src, out_bus.src_addr);
        check_field("hop_addr", want.hop, out_bus.hop_addr);
        check_field("frame_type", 16'(want.ftype), 16'(out_bus.frame_type));
        check_field("message_id", want.mid, out_bus.message_id);
        check_field("forward_flag", 16'(want.fwd), 16'(out_bus.forward_flag));
        check_field("last_of_frame", 16'(want.last), 16'(out_bus.last_of_frame));
      end
    end
  end

  // Output back-pressure: ready stretches, short stalls, rare long stalls.
  initial begin : result_backpressure
    int hold_n;
    int stall_n;
    int r;
    out_bus.ready = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      hold_n = (r < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      if (r < 40) stall_n = 0;
      else if (r < 88) stall_n = $urandom_range(1, 3);
      else if (r < 97) stall_n = $urandom_range(4, 12);
      else stall_n = $urandom_range(30, 60);
      repeat (hold_n) begin
        @(negedge clk);
        out_bus.ready <= 1'b1;
      end
      repeat (stall_n) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
      end
    end
  end

  // Reset register values: type 1 is data, type 0 is routing, own id 0.
  task automatic test_reset_values();
    send_header(16'h1234, 16'hABCD, 16'h0000, 8'h01, 16'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_word(16'h5A5A);
    send_route_frame(16'h0001, 16'h0002, 16'h0003, 16'd3);
    wait_drained();
  endtask

  // All-ones and all-zeros header fields, and a data frame without payload.
  task automatic test_header_extremes();
    send_header(16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 16'd1);
    send_byte(8'h80, 1'b0);
    send_word(16'hFFFF);
    send_data_frame(16'h0000, 16'hFFFF, 16'h0000, 8'h7F, 16'd0, 16'h0000);
    wait_drained();
  endtask

  // Routing frames with no entry, and with entries of extreme words.
  task automatic test_routing_frames();
    send_route_frame(16'h0101, 16'h0202, 16'h0303, 16'd0);
    send_route_frame(16'h0404, 16'h0505, 16'h0606, 16'd2);
    send_header(16'h0707, 16'h0808, 16'h0909, route_code, 16'd7);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h8000);
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h0001);
    // The seventh size unit carries no entry; this byte lands while idle.
    send_byte(8'h33, 1'b0);
    wait_drained();
  endtask

  // Idle bytes, bad preamble and packets abandoned by a new start.
  task automatic test_broken_packets();
    send_byte(8'h55, 1'b0);
    send_byte(PREAMBLE_BYTE, 1'b0);
    send_byte(8'hAB, 1'b1);
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_header(16'h1111, 16'h2222, 16'h3333, 8'h01, 16'd4);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_header(16'h4444, 16'h5555, 16'h6666, 8'h01, 16'hFFFF);
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_header(16'h7777, 16'h8888, 16'h9999, route_code, 16'hFFFF);
    repeat (5) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(PREAMBLE_BYTE, 1'b1);
    send_data_frame(16'hAAAA, 16'hBBBB, 16'hCCCC, 8'h01, 16'd3, 16'h2468);
    wait_drained();
  endtask

  // Extreme register values, masking of upper bits, unused index, equal codes.
  task automatic test_register_settings();
    write_reg(REG_OWN_NODE_ID, 16'hFFFF);
    write_reg(REG_ROUTING_TYPE, 16'hABFF);
    write_reg(REG_DATA_TYPE, 16'h0000);
    send_data_frame(16'h0010, 16'h0020, 16'hFFFF, 8'h00, 16'd1, 16'h0F0F);
    send_data_frame(16'h0030, 16'h0040, 16'hFFFE, 8'h00, 16'd1, 16'hF0F0);
    send_route_frame(16'h0050, 16'h0060, 16'hFFFF, 16'd6);
    wait_drained();
    write_reg(REG_UNUSED, 16'h1234);
    write_reg(REG_ROUTING_TYPE, 16'h0042);
    write_reg(REG_DATA_TYPE, 16'h0042);
    send_route_frame(16'h0070, 16'h0080, 16'hFFFF, 16'd4);
    send_data_frame(16'h0090, 16'h00A0, 16'hFFFF, 8'h00, 16'd2, 16'h1357);
    wait_drained();
  endtask

  // Random register setting with a bias toward the extremes.
  task automatic choose_config();
    int          r;
    logic [15:0] own_v;
    logic [15:0] route_v;
    logic [15:0] data_v;
    r = $urandom_range(0, 3);
    own_v = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    route_v = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 3);
    if (r == 0) route_v[7:0] = 8'h00;
    else if (r == 1) route_v[7:0] = 8'hFF;
    data_v = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 4);
    if (r == 0) data_v[7:0] = 8'h00;
    else if (r == 1) data_v[7:0] = 8'hFF;
    else if (r == 2) data_v[7:0] = route_v[7:0];
    write_reg(REG_OWN_NODE_ID, own_v);
    write_reg(REG_ROUTING_TYPE, route_v);
    write_reg(REG_DATA_TYPE, data_v);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
  endtask

  // One random packet: mostly well-formed frames, some noise and breakage.
  task automatic random_frame();
    int          r;
    logic [7:0]  b;
    logic [7:0]  ftype;
    logic [15:0] hop;
    logic [15:0] size;
    no_gaps = ($urandom_range(0, 3) == 0);
    hop = ($urandom_range(0, 9) < 4) ? own_id : 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 55) begin
      r = $urandom_range(0, 9);
      ftype = (r < 5) ? data_code : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 85) size = 16'($urandom_range(0, 16));
      else if (r < 97) size = 16'($urandom_range(17, 64));
      else size = 16'($urandom_range(245, 300));
      send_data_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      hop, ftype, size, 16'($urandom_range(0, 65535)));
    end else if (r < 85) begin
      size = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(0, 24))
                                        : 16'($urandom_range(25, 60));
      send_route_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       hop, size);
    end else begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        // Bytes without a start marker.
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (r == 1) begin
        // Bad preamble followed by a few bytes.
        b = 8'($urandom_range(0, 255));
        if (b == PREAMBLE_BYTE) b = b ^ 8'h01;
        send_byte(b, 1'b1);
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // Packet cut short; the next start abandons it.
        send_byte(PREAMBLE_BYTE, 1'b1);
        repeat ($urandom_range(0, 14)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      choose_config();
      target = bytes_parsed + RANDOM_BYTES / RANDOM_PHASES;
      while (bytes_parsed < target) random_frame();
      no_gaps = 1'b0;
      wait_drained();
    end
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.rx_byte = 8'h00;
    in_bus.packet_start = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_OWN_NODE_ID;
    cfg_bus.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_header_extremes();
    test_routing_frames();
    test_broken_packets();
    test_register_settings();
    test_random_traffic();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(64'd15_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
